[rtl/core/fpdo_pkg.sv]
// shared types and constants for the farthest pair distance ordering block
`default_nettype none
package fpdo_pkg;
    localparam int ROW_W  = 6;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 39;
    localparam int SQ_W   = 32;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // request to the distance unit
    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] row_a;
        logic [ROW_W-1:0] row_b;
    } dist_req_t;

    // answer from the distance unit
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] sum;
    } dist_rsp_t;
endpackage
`default_nettype wire

[rtl/core/fpdo_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module fpdo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/fpdo_dist.sv]
// squared distance unit: streams two rows from the store, saturating accumulate
`default_nettype none
module fpdo_dist #(
    parameter int MAX_ROWS   = 64,
    parameter int ROW_LENGTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fpdo_pkg::dist_req_t   req,
    output fpdo_pkg::dist_rsp_t        rsp,
    output logic [$clog2(MAX_ROWS*ROW_LENGTH)-1:0] raddr_a,
    output logic [$clog2(MAX_ROWS*ROW_LENGTH)-1:0] raddr_b,
    input  wire logic [fpdo_pkg::VAL_W-1:0] rdata_a,
    input  wire logic [fpdo_pkg::VAL_W-1:0] rdata_b
);
    import fpdo_pkg::*;

    localparam int AW = $clog2(MAX_ROWS*ROW_LENGTH);
    localparam int KW = $clog2(ROW_LENGTH+1);

    logic             issue_reg, issue_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [ROW_W-1:0] a_reg, a_next, b_reg, b_next;
    logic             v1_reg, l1_reg, v2_reg, l2_reg, v3_reg, l3_reg;
    logic signed [VAL_W:0] diff_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] mag;
    logic [DIST_W:0]  acc_sum;

    // element read addresses
    assign raddr_a = AW'(AW'(a_reg) * AW'(ROW_LENGTH) + AW'(k_reg));
    assign raddr_b = AW'(AW'(b_reg) * AW'(ROW_LENGTH) + AW'(k_reg));

    // issue control
    always_comb begin
        issue_next = issue_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        if (req.start) begin
            issue_next = 1'b1;
            k_next     = '0;
            a_next     = req.row_a;
            b_next     = req.row_b;
        end else if (issue_reg) begin
            k_next = k_reg + KW'(1);
            if (k_reg == KW'(ROW_LENGTH-1)) begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            issue_reg <= issue_next;
            v1_reg    <= issue_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    // magnitude of the difference
    assign mag = diff_reg[VAL_W] ? VAL_W'(-diff_reg) : VAL_W'(diff_reg);

    // saturating accumulate
    assign acc_sum = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
    always_comb begin
        acc_next = acc_reg;
        if (req.start) begin
            acc_next = '0;
        end else if (v3_reg) begin
            acc_next = (acc_sum > {1'b0, DIST_MAX}) ? DIST_MAX : acc_sum[DIST_W-1:0];
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        l1_reg   <= (k_reg == KW'(ROW_LENGTH-1));
        diff_reg <= $signed({rdata_a[VAL_W-1], rdata_a}) - $signed({rdata_b[VAL_W-1], rdata_b});
        l2_reg   <= l1_reg;
        sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
        l3_reg   <= l2_reg;
        acc_reg  <= acc_next;
    end

    assign rsp.done = v3_reg && l3_reg;
    assign rsp.sum  = acc_sum > {1'b0, DIST_MAX} ? DIST_MAX : acc_sum[DIST_W-1:0];
endmodule
`default_nettype wire

[rtl/core/farthest_pair_distance_ordering.sv]
// top level: descriptor store, pair search and distance ordering
//
// Input channel (s_*): one descriptor element per request, written into the
// store. A request with s_load_done set also starts the ordering, and s_ready
// stays low until the last result has been handed to the output register.
// Result channel (m_*): one result per row, n = rows_in_use clamped to
// 2..MAX_ROWS results, position 0 first, m_last_row set on the final one.
// After load_done the pair search runs n*(n-1)/2 distance computations
// through the shared distance unit with one read port per store copy; the
// distance fill takes up to n-2 more of those. Each middle position then
// scans the distance memory one row a cycle. A stalled receiver holds the
// output register and pauses the ordering at its next result until m_ready
// returns. Reset sets rows_in_use to 64, clears the control state and leaves
// the stores as they are; no clearing pass is needed. rows_in_use is written
// through cfg_we/cfg_wdata, which the user must do only while the block is
// idle; the block has no check for it.
`default_nettype none
module farthest_pair_distance_ordering #(
    parameter int MAX_ROWS   = 64,
    parameter int ROW_LENGTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [fpdo_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [fpdo_pkg::ROW_W-1:0]    s_row_index,
    input  wire logic [5:0]                    s_element_index,
    input  wire logic signed [fpdo_pkg::VAL_W-1:0] s_element_value,
    input  wire logic                          s_load_done,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fpdo_pkg::ROW_W-1:0]         m_new_position,
    output logic [fpdo_pkg::ROW_W-1:0]         m_source_row,
    output logic [fpdo_pkg::DIST_W-1:0]        m_squared_distance,
    output logic                               m_last_row
);
    import fpdo_pkg::*;

    localparam int AW = $clog2(MAX_ROWS*ROW_LENGTH);
    localparam int RW = $clog2(MAX_ROWS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PSTART = 4'd1;
    localparam logic [3:0] ST_PWAIT  = 4'd2;
    localparam logic [3:0] ST_FSTEP  = 4'd3;
    localparam logic [3:0] ST_FWAIT  = 4'd4;
    localparam logic [3:0] ST_EFIRST = 4'd5;
    localparam logic [3:0] ST_SCAN   = 4'd6;
    localparam logic [3:0] ST_SEMIT  = 4'd7;
    localparam logic [3:0] ST_ELAST  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  rows_reg, rows_next;
    logic [CNT_W-1:0]  n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]  pos_reg, pos_next, sj_reg, sj_next;
    logic [ROW_W-1:0]  first_reg, first_next, last_reg, last_next;
    logic [ROW_W-1:0]  pick_reg, pick_next, sidx_reg;
    logic [DIST_W-1:0] best_reg, best_next, sbest_reg, sbest_next;
    logic              found_reg, found_next, sv_reg;
    logic [MAX_ROWS-1:0] placed_reg, placed_next;
    logic              m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]  pos_out_reg, pos_out_next, src_out_reg, src_out_next;
    logic [DIST_W-1:0] dist_out_reg, dist_out_next;
    logic              last_out_reg, last_out_next;

    logic              s_fire, out_free, st_we;
    logic [AW-1:0]     st_waddr, raddr_a, raddr_b;
    logic [VAL_W-1:0]  rdata_a, rdata_b;
    dist_req_t         dreq;
    dist_rsp_t         drsp;
    logic              dm_we;
    logic [RW-1:0]     dm_waddr, dm_raddr;
    logic [DIST_W-1:0] dm_wdata, dm_rdata;
    logic [CNT_W-1:0]  n_clamped;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // store writes, two copies so both rows of a pair read in the same cycle
    assign st_we    = s_fire && (32'(s_row_index) < MAX_ROWS)
                             && (32'(s_element_index) < ROW_LENGTH);
    assign st_waddr = AW'(AW'(s_row_index) * AW'(ROW_LENGTH) + AW'(s_element_index));

    fpdo_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS*ROW_LENGTH)) u_store_a (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(s_element_value),
        .raddr(raddr_a), .rdata(rdata_a)
    );
    fpdo_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS*ROW_LENGTH)) u_store_b (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(s_element_value),
        .raddr(raddr_b), .rdata(rdata_b)
    );

    fpdo_dist #(.MAX_ROWS(MAX_ROWS), .ROW_LENGTH(ROW_LENGTH)) u_dist (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp),
        .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
    );

    // distance to the first row
    fpdo_ram #(.WIDTH(DIST_W), .DEPTH(MAX_ROWS)) u_dmem (
        .aclk(aclk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );
    assign dm_raddr = sj_reg[RW-1:0];

    // clamp of the row count
    assign n_clamped = (rows_reg < CNT_W'(2)) ? CNT_W'(2) :
                       (rows_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        rows_next     = cfg_we ? cfg_wdata : rows_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        sj_next       = sj_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        sbest_next    = sbest_reg;
        found_next    = found_reg;
        placed_next   = placed_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        pos_out_next  = pos_out_reg;
        src_out_next  = src_out_reg;
        dist_out_next = dist_out_reg;
        last_out_next = last_out_reg;
        dreq          = '0;
        dm_we         = 1'b0;
        dm_waddr      = i_reg[RW-1:0];
        dm_wdata      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_load_done) begin
                    n_next     = n_clamped;
                    i_next     = '0;
                    j_next     = CNT_W'(1);
                    first_next = '0;
                    last_next  = ROW_W'(1);
                    best_next  = '0;
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART: begin
                dreq.start = 1'b1;
                dreq.row_a = ROW_W'(i_reg);
                dreq.row_b = ROW_W'(j_reg);
                state_next = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (drsp.done) begin
                    if (drsp.sum > best_reg) begin
                        best_next  = drsp.sum;
                        first_next = ROW_W'(i_reg);
                        last_next  = ROW_W'(j_reg);
                    end
                    if (j_reg + CNT_W'(1) < n_reg) begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_PSTART;
                    end else if (i_reg + CNT_W'(2) < n_reg) begin
                        i_next     = i_reg + CNT_W'(1);
                        j_next     = i_reg + CNT_W'(2);
                        state_next = ST_PSTART;
                    end else begin
                        i_next     = '0;
                        state_next = ST_FSTEP;
                    end
                end
            end
            // i_reg walks the rows while filling the distance memory
            ST_FSTEP: begin
                if (i_reg == n_reg) begin
                    placed_next = '0;
                    placed_next[first_reg[RW-1:0]] = 1'b1;
                    placed_next[last_reg[RW-1:0]]  = 1'b1;
                    state_next  = ST_EFIRST;
                end else if (ROW_W'(i_reg) == first_reg) begin
                    dm_we    = 1'b1;
                    dm_wdata = '0;
                    i_next   = i_reg + CNT_W'(1);
                end else if (ROW_W'(i_reg) == last_reg) begin
                    dm_we    = 1'b1;
                    dm_wdata = best_reg;
                    i_next   = i_reg + CNT_W'(1);
                end else begin
                    dreq.start = 1'b1;
                    dreq.row_a = first_reg;
                    dreq.row_b = ROW_W'(i_reg);
                    state_next = ST_FWAIT;
                end
            end
            ST_FWAIT: begin
                if (drsp.done) begin
                    dm_we      = 1'b1;
                    dm_wdata   = drsp.sum;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_FSTEP;
                end
            end
            ST_EFIRST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    pos_out_next  = '0;
                    src_out_next  = first_reg;
                    dist_out_next = '0;
                    last_out_next = 1'b0;
                    pos_next      = CNT_W'(1);
                    sj_next       = '0;
                    found_next    = 1'b0;
                    state_next    = (n_reg == CNT_W'(2)) ? ST_ELAST : ST_SCAN;
                end
            end
            // one distance entry read per cycle, compared in the cycle after its read
            ST_SCAN: begin
                if (sj_reg < n_reg) begin
                    sj_next = sj_reg + CNT_W'(1);
                end
                if (sv_reg) begin
                    if (!placed_reg[sidx_reg[RW-1:0]] && (!found_reg || dm_rdata < sbest_reg)) begin
                        sbest_next = dm_rdata;
                        pick_next  = sidx_reg;
                        found_next = 1'b1;
                    end
                    if (CNT_W'(sidx_reg) == n_reg - CNT_W'(1)) begin
                        state_next = ST_SEMIT;
                    end
                end
            end
            ST_SEMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    pos_out_next  = ROW_W'(pos_reg);
                    src_out_next  = pick_reg;
                    dist_out_next = sbest_reg;
                    last_out_next = 1'b0;
                    placed_next[pick_reg[RW-1:0]] = 1'b1;
                    pos_next      = pos_reg + CNT_W'(1);
                    sj_next       = '0;
                    found_next    = 1'b0;
                    state_next    = (pos_reg + CNT_W'(2) < n_reg) ? ST_SCAN : ST_ELAST;
                end
            end
            ST_ELAST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    pos_out_next  = ROW_W'(n_reg - CNT_W'(1));
                    src_out_next  = last_reg;
                    dist_out_next = best_reg;
                    last_out_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rows_reg    <= CNT_W'(64);
            m_valid_reg <= 1'b0;
            placed_reg  <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            best_reg    <= '0;
            sv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rows_reg    <= rows_next;
            m_valid_reg <= m_valid_next;
            placed_reg  <= placed_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            best_reg    <= best_next;
            sv_reg      <= (state_reg == ST_SCAN) && (sj_reg < n_reg);
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        sj_reg       <= sj_next;
        sidx_reg     <= ROW_W'(sj_reg);
        pick_reg     <= pick_next;
        sbest_reg    <= sbest_next;
        found_reg    <= found_next;
        pos_out_reg  <= pos_out_next;
        src_out_reg  <= src_out_next;
        dist_out_reg <= dist_out_next;
        last_out_reg <= last_out_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_new_position     = pos_out_reg;
    assign m_source_row       = src_out_reg;
    assign m_squared_distance = dist_out_reg;
    assign m_last_row         = last_out_reg;
endmodule
`default_nettype wire

[rtl/core/fpdo_check.sv]
// port level checks for the farthest pair distance ordering block
`default_nettype none
module fpdo_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_load_done,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [5:0]  m_new_position,
    input wire logic [5:0]  m_source_row,
    input wire logic [38:0] m_squared_distance,
    input wire logic        m_last_row
);
    // a stalled result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_source_row)
            && $stable(m_squared_distance) && $stable(m_new_position))
        else $error("result changed while stalled");

    // the ordering starts right after the final element request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_load_done |=> !s_ready)
        else $error("accepted a request during ordering");

    // the first row of the order is at zero distance and is not the final result
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_position == 6'd0 |-> m_squared_distance == 39'd0 && !m_last_row)
        else $error("first row has nonzero distance");

    // the final result is never at position zero
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_row |-> m_new_position != 6'd0)
        else $error("final result at position zero");
endmodule

bind farthest_pair_distance_ordering fpdo_check u_fpdo_check (.*);
`default_nettype wire

[bench/tb_top.sv]
// self-checking testbench for the farthest pair distance ordering block
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fpdo_pkg::*;

    localparam int NROWS       = 64;
    localparam int NELEMS      = 64;
    localparam int LOADED_ROWS = 4;
    localparam int WD_LIMIT    = 400000;

    // one expected ordering result
    typedef struct {
        logic [ROW_W-1:0]  pos;
        logic [ROW_W-1:0]  src;
        logic [DIST_W-1:0] sqd;
        logic              last;
    } order_entry_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [ROW_W-1:0] s_row_index;
    logic [5:0] s_element_index;
    logic signed [VAL_W-1:0] s_element_value;
    logic s_load_done;
    logic m_valid;
    logic m_ready;
    logic [ROW_W-1:0] m_new_position;
    logic [ROW_W-1:0] m_source_row;
    logic [DIST_W-1:0] m_squared_distance;
    logic m_last_row;

    // mirror of the block state
    logic signed [VAL_W-1:0] desc_mirror [NROWS*NELEMS];
    logic [CNT_W-1:0] rows_setting;
    order_entry_t order_queue[$];
    int mismatches;
    int cyc;
    int hold_left;
    int quiet_cycles;

    farthest_pair_distance_ordering #(.MAX_ROWS(64), .ROW_LENGTH(64)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_row_index(s_row_index), .s_element_index(s_element_index),
        .s_element_value(s_element_value), .s_load_done(s_load_done),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_position(m_new_position), .m_source_row(m_source_row),
        .m_squared_distance(m_squared_distance), .m_last_row(m_last_row)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // idle decision, with a recurring calm window in which it never idles
    function automatic bit idle_now();
        if ((cyc % 2000) < 500) return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    // squared distance between two stored rows, saturating
    function automatic logic [DIST_W-1:0] row_sq_dist(int a, int b);
        longint acc;
        longint lim;
        longint d;
        acc = 0;
        lim = (64'd1 << DIST_W) - 1;
        for (int k = 0; k < NELEMS; k++) begin
            d = longint'(desc_mirror[a*NELEMS+k]) - longint'(desc_mirror[b*NELEMS+k]);
            acc += d * d;
            if (acc > lim) acc = lim;
        end
        return acc[DIST_W-1:0];
    endfunction

    // farthest pair search and ordering by distance to the first row
    task automatic predict_order();
        int n;
        int first;
        int last;
        int pick;
        bit found;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] dd;
        logic [DIST_W-1:0] low;
        logic [DIST_W-1:0] to_first [NROWS];
        bit placed [NROWS];
        order_entry_t e;
        n = rows_setting;
        if (n < 2) n = 2;
        if (n > NROWS) n = NROWS;
        first = 0;
        last = 1;
        best = row_sq_dist(0, 1);
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                dd = row_sq_dist(i, j);
                if (dd > best) begin
                    best = dd;
                    first = i;
                    last = j;
                end
            end
        end
        for (int i = 0; i < NROWS; i++) placed[i] = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i == first) to_first[i] = '0;
            else if (i == last) to_first[i] = best;
            else to_first[i] = row_sq_dist(first, i);
        end
        placed[first] = 1'b1;
        placed[last] = 1'b1;
        e.pos = '0; e.src = first[ROW_W-1:0]; e.sqd = '0; e.last = 1'b0;
        order_queue.push_back(e);
        for (int p = 1; p + 1 < n; p++) begin
            found = 1'b0;
            pick = 0;
            low = '0;
            for (int j = 0; j < n; j++) begin
                if (!placed[j] && (!found || to_first[j] < low)) begin
                    low = to_first[j];
                    pick = j;
                    found = 1'b1;
                end
            end
            placed[pick] = 1'b1;
            e.pos = p[ROW_W-1:0]; e.src = pick[ROW_W-1:0]; e.sqd = low; e.last = 1'b0;
            order_queue.push_back(e);
        end
        e.pos = ROW_W'(n - 1); e.src = last[ROW_W-1:0]; e.sqd = best; e.last = 1'b1;
        order_queue.push_back(e);
    endtask

    // send one element request; called and returns at a falling edge
    task automatic send_elem(int row, int elem, logic [VAL_W-1:0] val, bit done);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_row_index <= row[ROW_W-1:0];
        s_element_index <= elem[5:0];
        s_element_value <= val;
        s_load_done <= done;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        desc_mirror[row*NELEMS+elem] = val;
        if (done) predict_order();
        @(negedge aclk);
    endtask

    // write rows_in_use once all results are out
    task automatic set_rows(int v);
        s_valid <= 1'b0;
        while (order_queue.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[CNT_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        rows_setting = v[CNT_W-1:0];
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return VAL_W'($signed($urandom_range(4)) - 2);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // fill the rows in use with zeros and order them: every distance is zero
    task automatic test_preload_full();
        set_rows(LOADED_ROWS);
        for (int r = 0; r < LOADED_ROWS; r++)
            for (int k = 0; k < NELEMS; k++)
                send_elem(r, k, 16'h0000, (r == LOADED_ROWS - 1) && (k == NELEMS - 1));
    endtask

    // row count settings below the legal range and up to the loaded rows
    task automatic test_rows_extremes();
        set_rows(0);
        send_elem(1, 5, 16'h4000, 1'b1);
        set_rows(1);
        send_elem(0, 63, 16'hc000, 1'b1);
        set_rows(2);
        send_elem(1, 0, 16'h0000, 1'b1);
        set_rows(LOADED_ROWS);
        send_elem(LOADED_ROWS - 1, 63, 16'h8000, 1'b1);
    endtask

    // full scale element values of both signs
    task automatic test_value_extremes();
        set_rows(3);
        send_elem(0, 0, 16'h7fff, 1'b0);
        send_elem(1, 0, 16'h8000, 1'b0);
        send_elem(2, 0, 16'hffff, 1'b0);
        send_elem(0, 1, 16'h4000, 1'b0);
        send_elem(1, 1, 16'hc000, 1'b0);
        send_elem(2, 63, 16'h0001, 1'b1);
    endtask

    // small offsets in one element of otherwise equal rows
    task automatic test_all_equal();
        set_rows(LOADED_ROWS);
        send_elem(2, 7, 16'h0001, 1'b0);
        send_elem(1, 7, 16'hffff, 1'b0);
        send_elem(3, 7, 16'h0003, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_rows(LOADED_ROWS);
        hold_left = 3000;
        send_elem(0, 9, rand_value(), 1'b1);
        for (int i = 0; i < 6; i++)
            send_elem($urandom_range(LOADED_ROWS - 1), $urandom_range(63), rand_value(), 1'b0);
    endtask

    // random load sequences ending in an ordering
    task automatic test_random_orderings();
        int sent;
        int n;
        int len;
        sent = 0;
        n = LOADED_ROWS;
        while (sent < 40) begin
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(2, LOADED_ROWS);
                set_rows(n);
            end
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0)
                    send_elem($urandom_range(63), $urandom_range(63), rand_value(), 1'b0);
                else
                    send_elem($urandom_range(n - 1), $urandom_range(63), rand_value(), 1'b0);
            end
            send_elem($urandom_range(n - 1), $urandom_range(63), rand_value(), 1'b1);
            sent += len + 1;
        end
    endtask

    // result acceptor
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_now();
            end
        end
    end

    // result checker and inactivity watchdog
    always @(posedge aclk) begin
        order_entry_t e;
        cyc <= cyc + 1;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (order_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pos=%0d src=%0d", m_new_position, m_source_row);
            end else begin
                e = order_queue.pop_front();
                if (m_new_position !== e.pos || m_source_row !== e.src ||
                    m_squared_distance !== e.sqd || m_last_row !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp pos=%0d src=%0d dist=%0d last=%0d got %0d %0d %0d %0d",
                                 e.pos, e.src, e.sqd, e.last, m_new_position,
                                 m_source_row, m_squared_distance, m_last_row);
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_row_index = '0;
        s_element_index = '0;
        s_element_value = '0;
        s_load_done = 1'b0;
        rows_setting = 7'd64;
        mismatches = 0;
        cyc = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        test_preload_full();
        test_all_equal();
        test_rows_extremes();
        test_value_extremes();
        test_backpressure();
        test_random_orderings();
        s_valid <= 1'b0;
        while (order_queue.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && order_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/core/fpdo_pkg.sv
rtl/core/fpdo_ram.sv
rtl/core/fpdo_dist.sv
rtl/core/farthest_pair_distance_ordering.sv
rtl/core/fpdo_check.sv
bench/tb_top.sv
